[sv/slm_pkg.sv]
// shared types and constants for the sorted list merge block
package slm_pkg;

	localparam int unsigned MAX_LEN_A = 8;
	localparam int unsigned MAX_LEN_B = 8;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned LEN_W  = 4;
	localparam int unsigned MODE_W = 2;

	// list index and fill position widths
	localparam int unsigned IDX_A_W = (MAX_LEN_A > 1) ? $clog2(MAX_LEN_A) : 1;
	localparam int unsigned IDX_B_W = (MAX_LEN_B > 1) ? $clog2(MAX_LEN_B) : 1;
	localparam int unsigned POS_A_W = $clog2(MAX_LEN_A + 1);
	localparam int unsigned POS_B_W = $clog2(MAX_LEN_B + 1);

	// configuration register map
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_A = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_B = 1'd1;

	localparam logic [LEN_W-1:0] LEN_A_RST = 4'd5;
	localparam logic [LEN_W-1:0] LEN_B_RST = 4'd3;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_A = 2'd0,
		MODE_LOAD_B = 2'd1,
		MODE_MERGE  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_MERGE = 2'b10
	} state_t;

endpackage

[sv/slm_ifs.sv]
// valid/ready channel interfaces: item input, result output, register writes

interface slm_in_if;
	import slm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic signed [DATA_W-1:0] value;
	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);
endinterface

interface slm_out_if;
	import slm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] merged_value;
	logic                     last;
	modport source (output valid, output merged_value, output last, input ready);
	modport sink   (input valid, input merged_value, input last, output ready);
endinterface

interface slm_cfg_if;
	import slm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [LEN_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/sorted_list_merge_top.sv]
// merge of two ascending signed lists: load storage, merge sequencer, output register
//
// Two ascending lists of signed 32-bit values, A and B, are loaded one element per
// input beat (mode 0 into A, mode 1 into B; mode 3 is ignored), and after each
// load the block stays ready. Loads past the list capacity are dropped. A merge beat
// (mode 2) emits len_a + len_b results in ascending order, ties going to A first,
// and flags the final one with last; lengths above the capacity count as the
// capacity, and a merge of two empty lists emits nothing. The merge is run by a
// single signed comparator that picks one element per cycle while the output
// register is empty or being read, and the input is not ready during a merge.
// Results leave through a one-entry output register, so the input may accept loads
// while the final result still waits. A merge also rewinds both load positions.
// Elements must be loaded before a merge reads them. The list storage needs no
// clearing after reset. The user must write the length registers over the
// configuration channel only while the block is idle; the block does not enforce it.
module sorted_list_merge_top
	import slm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	slm_in_if.sink      src,
	slm_cfg_if.sink     cfg,
	slm_out_if.source   res
);

	// list storage, flops read at the merge pointers
	logic signed [DATA_W-1:0] list_a_q [MAX_LEN_A];
	logic signed [DATA_W-1:0] list_b_q [MAX_LEN_B];

	// fill positions
	logic [POS_A_W-1:0] load_pos_a_q;
	logic [POS_B_W-1:0] load_pos_b_q;

	// length registers
	logic [LEN_W-1:0] len_a_q;
	logic [LEN_W-1:0] len_b_q;

	// merge sequencer
	state_t             state_q;
	logic [POS_A_W-1:0] na_q, ia_q;
	logic [POS_B_W-1:0] nb_q, ib_q;

	// output register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic                     out_last_q;

	// input beat decode
	logic               src_fire;
	mode_t              src_mode;
	logic [POS_A_W-1:0] na_clamp;
	logic [POS_B_W-1:0] nb_clamp;

	// merge step
	logic                     slot_free;
	logic                     a_left, b_left;
	logic                     take_a;
	logic                     step;
	logic                     step_last;
	logic signed [DATA_W-1:0] head_a, head_b;

	assign src.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign src_fire  = src.valid && src.ready;
	assign src_mode  = mode_t'(src.mode);

	// lengths above capacity count as capacity
	assign na_clamp = ({{(32-LEN_W){1'b0}}, len_a_q} > MAX_LEN_A) ?
	                  POS_A_W'(MAX_LEN_A) : POS_A_W'(len_a_q);
	assign nb_clamp = ({{(32-LEN_W){1'b0}}, len_b_q} > MAX_LEN_B) ?
	                  POS_B_W'(MAX_LEN_B) : POS_B_W'(len_b_q);

	// the shared comparator: one pick per cycle while the output slot is free
	assign head_a    = list_a_q[ia_q[IDX_A_W-1:0]];
	assign head_b    = list_b_q[ib_q[IDX_B_W-1:0]];
	assign a_left    = (ia_q < na_q);
	assign b_left    = (ib_q < nb_q);
	assign take_a    = a_left && (!b_left || (head_a <= head_b));
	assign slot_free = !out_valid_q || res.ready;
	assign step      = (state_q == ST_MERGE) && slot_free;

	// final pick once both pointers reach their ends
	always_comb begin
		if (take_a) begin
			step_last = (ia_q + POS_A_W'(1) == na_q) && !b_left;
		end else begin
			step_last = (ib_q + POS_B_W'(1) == nb_q) && !a_left;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.merged_value = out_value_q;
	assign res.last         = out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= LEN_A_RST;
			len_b_q <= LEN_B_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_LEN_A: len_a_q <= cfg.data;
				REG_LEN_B: len_b_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// list storage writes, no reset needed
	always_ff @(posedge clk) begin
		if (src_fire && src_mode == MODE_LOAD_A && load_pos_a_q < POS_A_W'(MAX_LEN_A)) begin
			list_a_q[load_pos_a_q[IDX_A_W-1:0]] <= src.value;
		end
		if (src_fire && src_mode == MODE_LOAD_B && load_pos_b_q < POS_B_W'(MAX_LEN_B)) begin
			list_b_q[load_pos_b_q[IDX_B_W-1:0]] <= src.value;
		end
	end

	// fill positions and merge sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_a_q <= '0;
			load_pos_b_q <= '0;
			state_q      <= ST_IDLE;
			na_q         <= '0;
			nb_q         <= '0;
			ia_q         <= '0;
			ib_q         <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (src_fire) begin
						unique case (src_mode)
							MODE_LOAD_A: begin
								if (load_pos_a_q < POS_A_W'(MAX_LEN_A))
									load_pos_a_q <= load_pos_a_q + POS_A_W'(1);
							end
							MODE_LOAD_B: begin
								if (load_pos_b_q < POS_B_W'(MAX_LEN_B))
									load_pos_b_q <= load_pos_b_q + POS_B_W'(1);
							end
							MODE_MERGE: begin
								load_pos_a_q <= '0;
								load_pos_b_q <= '0;
								na_q         <= na_clamp;
								nb_q         <= nb_clamp;
								ia_q         <= '0;
								ib_q         <= '0;
								// two empty lists: nothing to emit
								if (na_clamp != '0 || nb_clamp != '0)
									state_q <= ST_MERGE;
							end
							default: ;
						endcase
					end
				end
				ST_MERGE: begin
					if (step) begin
						if (take_a)
							ia_q <= ia_q + POS_A_W'(1);
						else
							ib_q <= ib_q + POS_B_W'(1);
						if (step_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (step) begin
			out_value_q <= take_a ? head_a : head_b;
			out_last_q  <= step_last;
		end
	end

endmodule

[sv/slm_checker.sv]
// port-level checks on the merge block and the bind that attaches them
module slm_checker
	import slm_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     src_valid,
	input logic                     src_ready,
	input logic [MODE_W-1:0]        src_mode,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic signed [DATA_W-1:0] res_merged_value,
	input logic                     res_last
);

	// a result beat before the last one means a merge is still running
	a_busy_mid_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && !res_last) |-> !src_ready)
		else $error("input ready while a merge is still emitting");

	// a load beat leaves the block ready for the next one
	a_load_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && src_ready && (src_mode == MODE_LOAD_A || src_mode == MODE_LOAD_B))
		|=> src_ready)
		else $error("block went busy after a load beat");

	// no result appears while the block stays idle with no result pending
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(src_ready && $past(src_ready) && !$past(res_valid)) |-> !res_valid)
		else $error("result appeared without a merge in progress");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_merged_value)
		&& $stable(res_last)))
		else $error("stalled result changed");

endmodule

bind sorted_list_merge_top slm_checker u_slm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.src_valid        (src.valid),
	.src_ready        (src.ready),
	.src_mode         (src.mode),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_merged_value (res.merged_value),
	.res_last         (res.last)
);
